// ===== rtl/utf8_stream_decoder_assert.svh =====
// assertion macros shared by the utf8 stream decoder rtl
// expects signals clk and arst_n in the scope where a macro is used
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define UTF8D_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/utf8d_pkg.sv =====
// types, constants and lead byte classification for the utf8 stream decoder
// no dependencies
package utf8d_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CP_W      = 31;
	localparam int unsigned LEN_W     = 3;
	localparam int unsigned PAYLOAD_W = 7;
	localparam int unsigned TDATA_W   = ((CP_W + LEN_W + 7) / 8) * 8;
	localparam int unsigned TUSER_W   = 1;
	localparam logic [LEN_W-1:0] MAX_SEQ_LEN = 3'd6;

	// sequence state carried from byte to byte
	typedef struct packed {
		logic [LEN_W-1:0] remaining;
		logic [CP_W-1:0]  acc;
		logic [LEN_W-1:0] exp_len;
	} utf8d_state_t;

	// result of one byte
	typedef struct packed {
		logic             emit;
		logic             invalid;
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_length;
	} utf8d_result_t;

	// lead byte class: length zero marks a bad lead
	typedef struct packed {
		logic [LEN_W-1:0]     len;
		logic [PAYLOAD_W-1:0] payload;
	} utf8d_lead_t;

	function automatic utf8d_lead_t lead_decode(input logic [BYTE_W-1:0] b);
		utf8d_lead_t r;
		r.len = '0;
		r.payload = '0;
		priority if (b[7] == 1'b0) begin
			r.len = 3'd1;
			r.payload = b[6:0];
		end else if (b[7:5] == 3'b110) begin
			r.len = 3'd2;
			r.payload = {2'b00, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			r.len = 3'd3;
			r.payload = {3'b000, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			r.len = 3'd4;
			r.payload = {4'b0000, b[2:0]};
		end else if (b[7:2] == 6'b111110) begin
			r.len = 3'd5;
			r.payload = {5'b00000, b[1:0]};
		end else if (b[7:1] == 7'b1111110) begin
			r.len = MAX_SEQ_LEN;
			r.payload = {6'b000000, b[0]};
		end else begin
			r.len = '0;
			r.payload = '0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/utf8d_step.sv =====
// next state and result for one byte of the utf8 stream
// depends on utf8d_pkg
module utf8d_step (
	input  logic [utf8d_pkg::BYTE_W-1:0] data_byte,
	input  utf8d_pkg::utf8d_state_t      cur,
	output utf8d_pkg::utf8d_state_t      nxt,
	output utf8d_pkg::utf8d_result_t     res
);

	utf8d_pkg::utf8d_lead_t        lead;
	logic                          is_cont;
	logic [utf8d_pkg::CP_W-1:0]    acc_shift;
	logic [utf8d_pkg::LEN_W-1:0]   rem_dec;

	assign lead      = utf8d_pkg::lead_decode(data_byte);
	assign is_cont   = (data_byte[7:6] == 2'b10);
	assign acc_shift = {cur.acc[utf8d_pkg::CP_W-7:0], data_byte[5:0]};
	assign rem_dec   = cur.remaining - 3'd1;

	// sequence walker
	always_comb begin
		nxt = '0;
		res = '0;
		if (cur.remaining != '0) begin
			if (!is_cont) begin
				// bad continuation, count bytes used including this one
				res.emit = 1'b1;
				res.invalid = 1'b1;
				res.seq_length = cur.exp_len - cur.remaining + 3'd1;
			end else if (rem_dec == '0) begin
				res.emit = 1'b1;
				res.code_point = acc_shift;
				res.seq_length = cur.exp_len;
			end else begin
				nxt.remaining = rem_dec;
				nxt.acc = acc_shift;
				nxt.exp_len = cur.exp_len;
			end
		end else if (lead.len == '0) begin
			// bad lead
			res.emit = 1'b1;
			res.invalid = 1'b1;
			res.seq_length = 3'd1;
		end else if (lead.len == 3'd1) begin
			res.emit = 1'b1;
			res.code_point = {{(utf8d_pkg::CP_W-utf8d_pkg::PAYLOAD_W){1'b0}}, lead.payload};
			res.seq_length = 3'd1;
		end else begin
			nxt.remaining = lead.len - 3'd1;
			nxt.acc = {{(utf8d_pkg::CP_W-utf8d_pkg::PAYLOAD_W){1'b0}}, lead.payload};
			nxt.exp_len = lead.len;
		end
	end

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// utf8 stream decoder, one- to six-byte sequences, 31-bit code points
// registers: input register, then result register loaded from the byte that ends a sequence
// throughput: one byte per clock while the result register is free or drains, sequence state updated per byte
// reset: arst_n asynchronous, clears both valid stages and the sequence state to idle
// depends on utf8d_pkg, utf8d_step and utf8_stream_decoder_assert.svh
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [utf8d_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [utf8d_pkg::TDATA_W-1:0] m_axis_tdata,   // [30:0] code_point, [33:31] seq_length
	output logic [utf8d_pkg::TUSER_W-1:0] m_axis_tuser    // [0] invalid
);

	logic                          valid_s1;
	logic [utf8d_pkg::BYTE_W-1:0]  data_byte_s1;
	logic                          adv_s1;
	utf8d_pkg::utf8d_state_t       state_q;
	utf8d_pkg::utf8d_state_t       state_nxt;
	utf8d_pkg::utf8d_result_t      res;
	logic                          valid_s2;
	logic                          invalid_s2;
	logic [utf8d_pkg::CP_W-1:0]    code_point_s2;
	logic [utf8d_pkg::LEN_W-1:0]   seq_length_s2;

	// handshake: stage 1 moves on when the result register is free or drains
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_byte_s1 <= s_axis_tdata;
		end
	end

	// per-byte decode
	utf8d_step u_step (
		.data_byte (data_byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res)
	);

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && res.emit) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			invalid_s2 <= res.invalid;
			code_point_s2 <= res.code_point;
			seq_length_s2 <= res.seq_length;
		end
	end

	// output word
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(utf8d_pkg::TDATA_W-utf8d_pkg::CP_W-utf8d_pkg::LEN_W){1'b0}},
		seq_length_s2, code_point_s2};
	assign m_axis_tuser  = invalid_s2;

	// checks
	`UTF8D_ASSERT_ALWAYS(a_rem_below_len,
		(state_q.remaining == '0) || ((state_q.exp_len > state_q.remaining) &&
		(state_q.exp_len <= utf8d_pkg::MAX_SEQ_LEN)), "remaining count out of step with length")
	`UTF8D_ASSERT_ALWAYS(a_idle_clear,
		(state_q.remaining != '0) || ((state_q.acc == '0) && (state_q.exp_len == '0)),
		"idle state not cleared")
	`UTF8D_ASSERT_ALWAYS(a_len_range,
		!valid_s2 || ((seq_length_s2 != '0) && (seq_length_s2 <= utf8d_pkg::MAX_SEQ_LEN)),
		"result length out of range")
	`UTF8D_ASSERT_ALWAYS(a_invalid_zero,
		!valid_s2 || !invalid_s2 || (code_point_s2 == '0), "invalid result with nonzero code point")
	`UTF8D_ASSERT_NEXT(a_ascii_emits,
		adv_s1 && (state_q.remaining == '0) && !data_byte_s1[7],
		valid_s2 && !invalid_s2 && (seq_length_s2 == 3'd1), "ascii byte did not give a result")

endmodule

// ===== verif/utf8_stream_decoder_tb.sv =====
// self-checking testbench for utf8_stream_decoder: directed and random byte streams,
// predicted code points checked word by word against the master-side output
// depends on utf8d_pkg and the utf8_stream_decoder rtl
module utf8_stream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 80;
	localparam int RANDOM_BYTES = 550;

	typedef logic [utf8d_pkg::CP_W-1:0] cp_t;

	// one decoded character as it should leave the block
	typedef struct packed {
		logic [utf8d_pkg::CP_W-1:0]  code_point;
		logic                        invalid;
		logic [utf8d_pkg::LEN_W-1:0] seq_length;
	} decoded_char_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [utf8d_pkg::BYTE_W-1:0]   s_axis_tdata = '0;   // [7:0] data_byte
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [utf8d_pkg::TDATA_W-1:0]  m_axis_tdata;        // [30:0] code_point, [33:31] seq_length
	logic [utf8d_pkg::TUSER_W-1:0]  m_axis_tuser;        // [0] invalid

	logic [utf8d_pkg::BYTE_W-1:0]   tx_bytes[$];
	decoded_char_t                  decoded_q[$];
	int                             total_bytes = 0;
	int                             bytes_in = 0;
	int                             mismatches = 0;
	int                             stall_cycles = 0;
	int                             hold_left = 0;
	bit                             hold_done = 1'b0;
	logic [1:0]                     phase;

	// shadow of the decoder's sequence state
	logic [utf8d_pkg::LEN_W-1:0]    seq_left;
	logic [utf8d_pkg::CP_W-1:0]     seq_acc;
	logic [utf8d_pkg::LEN_W-1:0]    seq_len;

	utf8_stream_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// quarters of the stream: no idling, sender idle, receiver stall, both
	assign phase = (total_bytes == 0) ? 2'd0 : 2'((bytes_in * 4) / total_bytes);

	// advance the shadow state by one byte, returns 1 when a character completes or is found invalid
	function automatic bit decode_byte(input logic [utf8d_pkg::BYTE_W-1:0] b,
		output decoded_char_t r);
		logic [utf8d_pkg::LEN_W-1:0] lead_len;
		logic [utf8d_pkg::CP_W-1:0]  lead_bits;
		r = '0;
		if (seq_left != 0) begin
			if (b[7:6] != 2'b10) begin
				r.invalid = 1'b1;
				r.seq_length = seq_len - seq_left + 3'd1;
				seq_left = '0;
				seq_acc = '0;
				seq_len = '0;
				return 1'b1;
			end
			seq_acc = {seq_acc[utf8d_pkg::CP_W-7:0], b[5:0]};
			seq_left = seq_left - 3'd1;
			if (seq_left == 0) begin
				r.code_point = seq_acc;
				r.seq_length = seq_len;
				seq_acc = '0;
				seq_len = '0;
				return 1'b1;
			end
			return 1'b0;
		end
		lead_bits = '0;
		casez (b)
			8'b0???????: begin lead_len = 3'd1; lead_bits = cp_t'(b[6:0]); end
			8'b110?????: begin lead_len = 3'd2; lead_bits = cp_t'(b[4:0]); end
			8'b1110????: begin lead_len = 3'd3; lead_bits = cp_t'(b[3:0]); end
			8'b11110???: begin lead_len = 3'd4; lead_bits = cp_t'(b[2:0]); end
			8'b111110??: begin lead_len = 3'd5; lead_bits = cp_t'(b[1:0]); end
			8'b1111110?: begin lead_len = 3'd6; lead_bits = cp_t'(b[0]); end
			default:     lead_len = 3'd0;
		endcase
		// continuation byte or 0xfe/0xff while idle
		if (lead_len == 0) begin
			r.invalid = 1'b1;
			r.seq_length = 3'd1;
			return 1'b1;
		end
		if (lead_len == 1) begin
			r.code_point = lead_bits;
			r.seq_length = 3'd1;
			return 1'b1;
		end
		seq_acc = lead_bits;
		seq_len = lead_len;
		seq_left = lead_len - 3'd1;
		return 1'b0;
	endfunction

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (tx_bytes.size() != 0 &&
			    $urandom_range(99) >= ((phase == 2'd1) ? 68 : (phase == 2'd3) ? 26 : 0)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= tx_bytes.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver ready, with one long hold-off early in the run
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && bytes_in >= 30) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= $urandom_range(99) >= ((phase == 2'd2) ? 68 :
			                                        (phase == 2'd3) ? 26 : 0);
		end
	end

	// predict on each accepted byte, check each accepted result word
	always @(posedge clk or negedge arst_n) begin
		decoded_char_t want;
		decoded_char_t got;
		if (!arst_n) begin
			seq_left = '0;
			seq_acc = '0;
			seq_len = '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_in <= bytes_in + 1;
				if (decode_byte(s_axis_tdata, want))
					decoded_q.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.code_point = m_axis_tdata[utf8d_pkg::CP_W-1:0];
				got.seq_length = m_axis_tdata[utf8d_pkg::CP_W+utf8d_pkg::LEN_W-1:utf8d_pkg::CP_W];
				got.invalid = m_axis_tuser[0];
				if (decoded_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected word: cp=%h invalid=%b len=%0d",
						         got.code_point, got.invalid, got.seq_length);
					mismatches <= mismatches + 1;
				end else begin
					want = decoded_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display("mismatch: expected %h %b %0d, got %h %b %0d",
							         want.code_point, want.invalid, want.seq_length,
							         got.code_point, got.invalid, got.seq_length);
						mismatches <= mismatches + 1;
					end
				end
			end
			// watchdog on cycles where no word moves on either side
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [utf8d_pkg::BYTE_W-1:0] b;
		int                           kind;
		int                           len;
		int                           good;
		bit                           timed_out;

		// directed: ascii extremes, longest legal values, bad leads, bad continuations
		tx_bytes = '{8'h00, 8'h7f,
		             8'hdf, 8'hbf,
		             8'hef, 8'hbf, 8'hbf,
		             8'hfd, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,
		             8'h80, 8'hfe, 8'hff,
		             8'hf0, 8'h41,
		             8'hfc, 8'h80, 8'h80, 8'h80, 8'h80, 8'hc0};

		// random: mostly well-formed sequences, some broken ones, some noise
		while (tx_bytes.size() < RANDOM_BYTES + 24) begin
			kind = $urandom_range(99);
			if (kind < 10) begin
				tx_bytes.push_back(8'($urandom));
			end else begin
				len = $urandom_range(1, 6);
				good = (kind < 22 && len > 1) ? $urandom_range(1, len - 1) : len;
				case (len)
					1:       b = {1'b0, 7'($urandom)};
					2:       b = {3'b110, 5'($urandom)};
					3:       b = {4'b1110, 4'($urandom)};
					4:       b = {5'b11110, 3'($urandom)};
					5:       b = {6'b111110, 2'($urandom)};
					default: b = {7'b1111110, 1'($urandom)};
				endcase
				tx_bytes.push_back(b);
				for (int i = 1; i < good; i++)
					tx_bytes.push_back({2'b10, 6'($urandom)});
				// cut the sequence short with a byte that is not a continuation
				if (good < len) begin
					do b = 8'($urandom); while (b[7:6] == 2'b10);
					tx_bytes.push_back(b);
				end
			end
		end
		total_bytes = tx_bytes.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		timed_out = 1'b0;
		while (!(bytes_in == total_bytes && decoded_q.size() == 0)) begin
			@(posedge clk);
			if (stall_cycles >= STALL_LIMIT) begin
				timed_out = 1'b1;
				break;
			end
		end
		if (!timed_out)
			repeat (10) @(posedge clk);

		if (!timed_out && mismatches == 0 && decoded_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
